/* hw/rtl/lru_recency_list_macros.svh */
// Assertion macros shared by the recency list RTL.
// Included by the files that carry concurrent checks; needs no other file.
`ifndef LRU_RECENCY_LIST_MACROS_SVH
`define LRU_RECENCY_LIST_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under the synchronous reset.
`define LRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru_recency_list check failed");
// Next-cycle implication under the synchronous reset.
`define LRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_recency_list check failed");
`else
`define LRL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LRL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/lrl_pkg.sv */
// Types and codes for the recency list: operations, result status, sequencer states.
// Has no dependencies; used by lrl_seq and lru_recency_list.
`timescale 1ns / 1ps

package lrl_pkg;

  typedef enum logic [1:0] {
    OP_TOUCH  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BUSY      = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_TAIL,
    S_FETCH,
    S_FINISH
  } seq_state_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic    valid;
    status_t status;
  } rsp_t;

endpackage

/* hw/rtl/lrl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the recency-ordered keys.
`timescale 1ns / 1ps

module lrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/lrl_seq.sv */
// Sequencer of the recency list: scans the key RAM with one comparator and
// closes gaps one cell at a time. Depends on lrl_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "lru_recency_list_macros.svh"

module lrl_seq import lrl_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input transaction
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_operation,
  input  logic [KEY_WIDTH-1:0]       in_item_key,
  input  logic                       in_entry_busy,
  // Key RAM
  output logic                       ram_wr_en,
  output logic [$clog2(DEPTH)-1:0]   ram_wr_addr,
  output logic [KEY_WIDTH-1:0]       ram_wr_data,
  output logic                       ram_rd_en,
  output logic [$clog2(DEPTH)-1:0]   ram_rd_addr,
  input  logic [KEY_WIDTH-1:0]       ram_rd_data,
  // Result towards the output register
  output rsp_t                       rsp,
  input  logic                       rsp_take,
  output logic [KEY_WIDTH-1:0]       rsp_oldest_key,
  output logic [$clog2(DEPTH+1)-1:0] rsp_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  seq_state_t           state_r, state_nxt;
  op_e_t                op_r, op_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                 busy_r, busy_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  status_t              status_r, status_nxt;

  op_e_t         in_op;
  logic          accept;
  logic          hit;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_p2;
  logic          at_last;
  logic          shift_last;
  logic          is_full;
  logic          is_empty;

  assign in_op      = op_e_t'(in_operation);
  assign accept     = in_valid && in_ready;
  assign hit        = (ram_rd_data == key_r);
  assign idx_p1     = CW'(idx_r) + CW'(1);
  assign idx_p2     = CW'(idx_r) + CW'(2);
  assign at_last    = (idx_p1 == cnt_r);
  assign shift_last = (idx_p2 == cnt_r);
  assign is_full    = (cnt_r == CW'(DEPTH));
  assign is_empty   = (cnt_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_op == OP_TOUCH || in_op == OP_REMOVE) && !is_empty) begin
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (hit) begin
          if ((op_r == OP_REMOVE && idx_r == '0 && busy_r) || at_last) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else if (at_last) begin
          state_nxt = S_FETCH;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (shift_last) begin
          state_nxt = (op_r == OP_TOUCH) ? S_TAIL : S_FETCH;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_TAIL:  state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_FINISH;
      S_FINISH: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake and RAM controls.
  always_comb begin
    in_ready    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = key_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = idx_r;
    rsp.valid   = 1'b0;
    rsp.status  = status_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        // A touch on an empty store writes the first cell straight away.
        if (in_valid && in_op == OP_TOUCH && is_empty) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = '0;
          ram_wr_data = in_item_key;
        end
      end
      S_SCAN_RD: ram_rd_en = 1'b1;
      S_SCAN_CMP: begin
        // An absent key is appended behind the most recent one.
        if (!hit && at_last && op_r == OP_TOUCH && !is_full) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = cnt_r[AW-1:0];
        end
      end
      S_SHIFT_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_p1[AW-1:0];
      end
      S_SHIFT_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data;
      end
      S_TAIL: ram_wr_en = 1'b1;
      S_FETCH: begin
        ram_rd_en   = !is_empty;
        ram_rd_addr = '0;
      end
      S_FINISH: rsp.valid = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers: latched transaction, count, index and status.
  always_comb begin
    op_nxt     = op_r;
    key_nxt    = key_r;
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_op;
          key_nxt    = in_item_key;
          busy_nxt   = in_entry_busy;
          idx_nxt    = '0;
          status_nxt = ST_DONE;
          if (in_op == OP_CLEAR) begin
            cnt_nxt = '0;
          end else if (in_op == OP_TOUCH && is_empty) begin
            cnt_nxt = CW'(1);
          end else if (in_op == OP_REMOVE && is_empty) begin
            status_nxt = ST_NOT_FOUND;
          end
        end
      end
      S_SCAN_CMP: begin
        if (hit) begin
          if (op_r == OP_REMOVE && idx_r == '0 && busy_r) begin
            status_nxt = ST_BUSY;
          end else if (at_last && op_r == OP_REMOVE) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end else if (at_last) begin
          if (op_r == OP_REMOVE) begin
            status_nxt = ST_NOT_FOUND;
          end else if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end else begin
          idx_nxt = idx_p1[AW-1:0];
        end
      end
      S_SHIFT_WR: begin
        idx_nxt = idx_p1[AW-1:0];
        if (shift_last && op_r == OP_REMOVE) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    busy_r   <= busy_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

  // The oldest key was fetched from cell 0 in the cycle before the result.
  assign rsp_oldest_key = is_empty ? '0 : ram_rd_data;
  assign rsp_count      = cnt_r;

  `LRL_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH))
  `LRL_ASSERT_NXT(a_clear_empties, clk, rst_n, accept && in_op == OP_CLEAR, cnt_r == '0)
  `LRL_ASSERT_NXT(a_finish_holds, clk, rst_n, rsp.valid && !rsp_take,
                  rsp.valid && $stable(rsp.status) && $stable(cnt_r))
  `LRL_ASSERT_NOW(a_no_write_on_full, clk, rst_n, ram_wr_en && state_r == S_SCAN_CMP,
                  !is_full)

endmodule

/* hw/rtl/lru_recency_list.sv */
// Top level of the recency list: key RAM, sequencer and the result register.
// Depends on lrl_pkg, lrl_ram, lrl_seq and the assertion macros.
`timescale 1ns / 1ps
`include "lru_recency_list_macros.svh"

// Keeps up to DEPTH keys ordered from least to most recently used in a RAM with
// one write and one registered read port, driven by a small sequencer with a
// single key comparator. One transaction is taken at a time; in_ready is low
// while it is worked on. A clear, an unused operation, or any operation on an
// empty store goes straight to the fetch of the oldest key and then the finish
// state, which waits until the output register is free; the sequencer returns
// to idle for the next transaction once the result has been taken. A touch or
// remove reads and compares the cells from the oldest, one at a time, then
// closes the gap behind a found key by reading and writing each moved cell (and
// places a touched key at the most recent end), then fetches the oldest key and
// presents the result. Cells examined and cells moved together never exceed
// the count. A result waits in the output register while the next transaction
// is already being accepted.
module lru_recency_list import lrl_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_operation,
  input  logic [KEY_WIDTH-1:0]       in_item_key,
  input  logic                       in_entry_busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [KEY_WIDTH-1:0]       out_oldest_key,
  output logic                       out_oldest_valid,
  output logic [$clog2(DEPTH+1)-1:0] out_entry_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [KEY_WIDTH-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [KEY_WIDTH-1:0] ram_rd_data;

  rsp_t                 rsp;
  logic                 rsp_take;
  logic [KEY_WIDTH-1:0] rsp_oldest_key;
  logic [CW-1:0]        rsp_count;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;
  logic [KEY_WIDTH-1:0] out_oldest_key_r;
  logic [CW-1:0]        out_entry_count_r;

  lrl_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lrl_seq #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_item_key    (in_item_key),
    .in_entry_busy  (in_entry_busy),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_en      (ram_rd_en),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data),
    .rsp            (rsp),
    .rsp_take       (rsp_take),
    .rsp_oldest_key (rsp_oldest_key),
    .rsp_count      (rsp_count)
  );

  // The result register is free when empty or being drained this cycle.
  assign rsp_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp.valid && rsp_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload loads together with the valid flag.
  always_ff @(posedge clk) begin
    if (rsp.valid && rsp_take) begin
      out_status_r      <= rsp.status;
      out_oldest_key_r  <= rsp_oldest_key;
      out_entry_count_r <= rsp_count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_oldest_key   = out_oldest_key_r;
  assign out_oldest_valid = (out_entry_count_r != '0);
  assign out_entry_count  = out_entry_count_r;

  `LRL_ASSERT_NOW(a_out_count_bound, clk, rst_n, out_valid_r,
                  out_entry_count_r <= CW'(DEPTH))
  `LRL_ASSERT_NOW(a_empty_key_zero, clk, rst_n, out_valid_r && out_entry_count_r == '0,
                  out_oldest_key_r == '0)
  `LRL_ASSERT_NOW(a_one_in_flight, clk, rst_n, in_ready, !rsp.valid)

endmodule
